// File: hdl/ftrl_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the FTRL learner.
package ftrl_pkg;

    localparam int INDEX_BITS_DEF = 12;
    localparam int SLOT_W   = 12;
    localparam int PROB_W   = 17;
    localparam int DROP_W   = 17;
    localparam int WORD_W   = 32;
    localparam int GRAD_W   = 18;
    localparam int CFG_IDX_W = 3;
    localparam int SQ_IN_W  = 48;
    localparam int SQ_OUT_W = 24;
    localparam int SQ_CNT_W = 5;
    localparam int DIV_W    = 64;
    localparam int DIV_CNT_W = 6;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 66;
    localparam int STEP_W   = 51;

    localparam logic [PROB_W-1:0] ONE_Q16 = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP  = 3'd4;

    localparam logic [WORD_W-1:0] ALPHA_RST = 32'd6554;
    localparam logic [WORD_W-1:0] BETA_RST  = 32'd65536;
    localparam logic [WORD_W-1:0] L1_RST    = 32'd65536;
    localparam logic [WORD_W-1:0] L2_RST    = 32'd65536;
    localparam logic [DROP_W-1:0] DROP_RST  = 17'd0;

    typedef enum logic [5:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_GRAD,
        ST_LB_SEL, ST_LF_SEL, ST_L_WAIT, ST_L_CAP, ST_L_SQ0, ST_L_SQ1,
        ST_L_SIG, ST_L_PMUL, ST_L_ZUPD, ST_L_BR,
        ST_B_MUL, ST_B_DIV, ST_B_WAIT,
        ST_F_ZERO, ST_F_D1, ST_F_W1, ST_F_D2, ST_F_W2,
        ST_O_SEL, ST_O_WAIT, ST_O_CAP,
        ST_P_SEL, ST_P_WAIT, ST_P_ACC,
        ST_FIN, ST_E_SEL, ST_E_WAIT, ST_E_CAP, ST_E_MUL, ST_E_ADD, ST_EMIT
    } ctl_state_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_CLEAR, OP_LOAD, OP_GRAD, OP_SEL_BIAS, OP_SEL_FEAT,
        OP_CAP, OP_SQ0, OP_SQ1, OP_SIG, OP_PMUL, OP_ZUPD,
        OP_BMUL, OP_BDIV, OP_WSET, OP_WZERO, OP_FD1, OP_FW1, OP_FD2,
        OP_OPEN, OP_ACC, OP_W0, OP_EMUL, OP_EADD, OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic clear_done;
        logic sq_done;
        logic dv_done;
        logic open;
        logic is_update;
        logic idx_zero;
        logic last;
        logic eval;
        logic bias;
        logic small_z;
        logic out_full;
    } dp_status_t;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > 66'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

    function automatic logic signed [WORD_W-1:0] from_mag(input logic neg,
                                                          input logic [DIV_W-1:0] q);
        logic signed [WORD_W-1:0] r;
        if (neg)
            r = (q >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(q[WORD_W-1:0]);
        else
            r = (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[WORD_W-1:0]);
        return r;
    endfunction

endpackage

// File: hdl/ftrl_if.sv
`timescale 1ns / 1ps
// Handshake channel interfaces for items, results and register writes.
interface ftrl_item_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [11:0] feature_slot;
    logic        last_feature;
    logic        evaluate_mode;
    logic [16:0] probability;
    logic        target_label;

    modport source (output valid, operation, feature_slot, last_feature, evaluate_mode,
                    probability, target_label, input ready);
    modport sink (input valid, operation, feature_slot, last_feature, evaluate_mode,
                  probability, target_label, output ready);
endinterface

interface ftrl_result_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic signed [31:0] raw_score;
    logic signed [31:0] bias_weight;

    modport source (output valid, result_kind, raw_score, bias_weight, input ready);
    modport sink (input valid, result_kind, raw_score, bias_weight, output ready);
endinterface

interface ftrl_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/ftrl_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ftrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: hdl/ftrl_sqrt.sv
`timescale 1ns / 1ps
// Bit-serial integer square root, one result bit per cycle.
module ftrl_sqrt
    import ftrl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SQ_IN_W-1:0]  radicand,
    output logic                done,
    output logic [SQ_OUT_W-1:0] root
);
    logic [SQ_IN_W-1:0]  rad_reg;
    logic [25:0]         rem_reg;
    logic [SQ_OUT_W-1:0] root_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic                busy_reg;
    logic [27:0]         rem_try;
    logic [27:0]         trial;
    logic                fits;

    assign rem_try = {rem_reg, rad_reg[SQ_IN_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign fits    = rem_try >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= SQ_CNT_W'(SQ_OUT_W - 1);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SQ_IN_W-3:0], 2'b00};
            rem_reg  <= fits ? 26'(rem_try - trial) : rem_try[25:0];
            root_reg <= {root_reg[SQ_OUT_W-2:0], fits};
            cnt_reg  <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign done = !busy_reg;
    assign root = root_reg;
endmodule

// File: hdl/ftrl_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module ftrl_div
    import ftrl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [DIV_W:0]       rem_try;
    logic                 fits;

    assign rem_try = {rem_reg, quo_reg[DIV_W-1]};
    assign fits    = rem_try >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
            cnt_reg  <= DIV_CNT_W'(DIV_W - 1);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? DIV_W'(rem_try - {1'b0, dsr_reg}) : rem_try[DIV_W-1:0];
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign done     = !busy_reg;
    assign quotient = quo_reg;
endmodule

// File: hdl/ftrl_datapath.sv
`timescale 1ns / 1ps
// Datapath: tables, registers, shared multiplier, square root and divider.
module ftrl_datapath
    import ftrl_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_op_t                   op,
    output dp_status_t               status,
    input  logic                     operation,
    input  logic [SLOT_W-1:0]        feature_slot,
    input  logic                     last_feature,
    input  logic                     evaluate_mode,
    input  logic [PROB_W-1:0]        probability,
    input  logic                     target_label,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [WORD_W-1:0]        cfg_data,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic                     result_kind,
    output logic signed [WORD_W-1:0] raw_score,
    output logic signed [WORD_W-1:0] bias_weight
);
    localparam int DEPTH = 1 << INDEX_BITS;
    localparam int EXT_W = SLOT_W + INDEX_BITS;

    logic                     upd_reg, last_reg, eval_reg, label_reg, open_reg, bias_reg;
    logic [INDEX_BITS-1:0]    idx_reg, slot_reg, clear_cnt_reg;
    logic [PROB_W-1:0]        prob_reg;
    logic signed [GRAD_W-1:0] gradient_reg;
    logic [WORD_W-1:0]        nn_reg;
    logic signed [WORD_W-1:0] w_reg, z_reg, acc_reg, w0_reg, score_reg;
    logic [SQ_OUT_W-1:0]      s0_reg, s1_reg;
    logic [30:0]              sigma_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [PROD_W-1:0] mul_reg;
    logic                     out_valid_reg, out_kind_reg;
    logic signed [WORD_W-1:0] out_score_reg, out_bias_reg;
    logic [WORD_W-1:0]        alpha_reg, beta_reg, l1_reg, l2_reg;
    logic [DROP_W-1:0]        drop_reg;

    logic [EXT_W-1:0]         slot_ext;
    logic [PROB_W-1:0]        prob_clamp;
    logic [WORD_W-1:0]        alpha_eff;
    logic [PROB_W-1:0]        keep;
    logic [32:0]              nsum;
    logic [WORD_W-1:0]        nn_sat;
    logic [32:0]              bs_sum;
    logic [32:0]              den;
    logic signed [32:0]       z_neg;
    logic [WORD_W-1:0]        absz;
    logic                     z_pos;
    logic signed [PROD_W-1:0] mul_trunc, zsum, accsum, scoresum;
    logic signed [WORD_W-1:0] z_new;
    logic [STEP_W-1:0]        step_sum;
    logic [30:0]              sigma_clip;
    logic signed [MUL_W-1:0]  mul_a, mul_b, diff;
    logic signed [PROD_W-1:0] mul_prod;
    logic                     mul_load;
    logic                     sq_start, sq_done;
    logic [SQ_IN_W-1:0]       sq_rad;
    logic [SQ_OUT_W-1:0]      sq_root;
    logic                     dv_start, dv_done;
    logic [DIV_W-1:0]         dv_num, dv_den, dv_quo;
    logic                     w_we, nz_we, emit_fire;
    logic [INDEX_BITS-1:0]    waddr;
    logic [WORD_W-1:0]        w_wdata, n_wdata, z_wdata, rdata_w, rdata_n, rdata_z;

    assign slot_ext   = EXT_W'(feature_slot);
    assign prob_clamp = (probability > ONE_Q16) ? ONE_Q16 : probability;
    assign alpha_eff  = (alpha_reg == '0) ? 32'd1 : alpha_reg;
    assign keep       = (drop_reg > ONE_Q16) ? '0 : PROB_W'(ONE_Q16 - drop_reg);
    assign nsum       = {1'b0, rdata_n} + 33'(mul_reg[32:16]);
    assign nn_sat     = nsum[32] ? '1 : nsum[31:0];
    assign bs_sum     = {1'b0, beta_reg} + 33'(s1_reg);
    assign den        = (bs_sum == '0) ? 33'd1 : bs_sum;
    assign z_neg      = -(33'(z_reg));
    assign absz       = z_reg[31] ? z_neg[31:0] : z_reg[31:0];
    assign z_pos      = !z_reg[31] && (z_reg != '0);
    assign mul_trunc  = mul_reg[PROD_W-1] ? ((mul_reg + 66'sd65535) >>> 16) : (mul_reg >>> 16);
    assign zsum       = 66'(z_reg) + 66'(gradient_reg) - mul_trunc;
    assign z_new      = sat32(zsum);
    assign accsum     = 66'(acc_reg) + 66'($signed(rdata_w));
    assign scoresum   = mul_trunc + 66'(w0_reg);
    assign step_sum   = STEP_W'(l2_reg) + dv_quo[STEP_W-1:0];
    assign sigma_clip = (dv_quo > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : dv_quo[30:0];
    assign diff       = 33'(acc_reg) - 33'(w0_reg);
    assign emit_fire  = (op == OP_EMIT) && !out_valid_reg;

    always_comb
    begin
        mul_load = 1'b1;
        case (op)
            OP_SEL_BIAS, OP_SEL_FEAT:
            begin
                mul_a = 33'(gradient_reg);
                mul_b = 33'(gradient_reg);
            end
            OP_PMUL:
            begin
                mul_a = $signed({2'b00, sigma_reg});
                mul_b = 33'(w_reg);
            end
            OP_BMUL:
            begin
                mul_a = $signed({1'b0, absz});
                mul_b = $signed({1'b0, alpha_eff});
            end
            OP_EMUL:
            begin
                mul_a = diff;
                mul_b = $signed({16'b0, keep});
            end
            default:
            begin
                mul_a    = '0;
                mul_b    = '0;
                mul_load = 1'b0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    assign sq_start = (op == OP_CAP) || ((op == OP_SQ0) && sq_done);
    assign sq_rad   = (op == OP_CAP) ? {rdata_n, 16'b0} : {nn_reg, 16'b0};

    always_comb
    begin
        dv_start = 1'b0;
        dv_num   = '0;
        dv_den   = 64'd1;
        case (op)
            OP_SQ1:
            begin
                dv_start = sq_done;
                dv_num   = {24'b0, SQ_OUT_W'(sq_root - s0_reg), 16'b0};
                dv_den   = 64'(alpha_eff);
            end
            OP_BDIV:
            begin
                dv_start = 1'b1;
                dv_num   = mul_reg[DIV_W-1:0];
                dv_den   = 64'(den);
            end
            OP_FD1:
            begin
                dv_start = 1'b1;
                dv_num   = {15'b0, bs_sum, 16'b0};
                dv_den   = 64'(alpha_eff);
            end
            OP_FD2:
            begin
                dv_start = 1'b1;
                dv_num   = {16'b0, WORD_W'(absz - l1_reg), 16'b0};
                dv_den   = 64'(step_reg);
            end
            default:
            begin
                dv_start = 1'b0;
            end
        endcase
    end

    assign w_we    = (op == OP_CLEAR) || (op == OP_WZERO) || ((op == OP_WSET) && dv_done);
    assign nz_we   = (op == OP_CLEAR) || (op == OP_ZUPD);
    assign waddr   = (op == OP_CLEAR) ? clear_cnt_reg : slot_reg;
    assign w_wdata = (op == OP_WSET) ? from_mag(z_pos, dv_quo) : '0;
    assign n_wdata = (op == OP_ZUPD) ? nn_reg : '0;
    assign z_wdata = (op == OP_ZUPD) ? z_new : '0;

    ftrl_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    ftrl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (dv_num),
        .divisor  (dv_den),
        .done     (dv_done),
        .quotient (dv_quo)
    );

    ftrl_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_weight_ram (
        .clk (clk), .we (w_we), .waddr (waddr), .wdata (w_wdata),
        .raddr (slot_reg), .rdata (rdata_w)
    );

    ftrl_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_gradsq_ram (
        .clk (clk), .we (nz_we), .waddr (waddr), .wdata (n_wdata),
        .raddr (slot_reg), .rdata (rdata_n)
    );

    ftrl_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_z_ram (
        .clk (clk), .we (nz_we), .waddr (waddr), .wdata (z_wdata),
        .raddr (slot_reg), .rdata (rdata_z)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RST;
            beta_reg  <= BETA_RST;
            l1_reg    <= L1_RST;
            l2_reg    <= L2_RST;
            drop_reg  <= DROP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALPHA: alpha_reg <= cfg_data;
                CFG_BETA:  beta_reg  <= cfg_data;
                CFG_L1:    l1_reg    <= cfg_data;
                CFG_L2:    l2_reg    <= cfg_data;
                CFG_DROP:  drop_reg  <= cfg_data[DROP_W-1:0];
                default:   drop_reg  <= drop_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_reg       <= 1'b0;
            last_reg      <= 1'b0;
            eval_reg      <= 1'b0;
            label_reg     <= 1'b0;
            open_reg      <= 1'b0;
            bias_reg      <= 1'b0;
            idx_reg       <= '0;
            slot_reg      <= '0;
            clear_cnt_reg <= '0;
            prob_reg      <= '0;
            gradient_reg  <= '0;
            nn_reg        <= '0;
            w_reg         <= '0;
            z_reg         <= '0;
            acc_reg       <= '0;
            w0_reg        <= '0;
            score_reg     <= '0;
            s0_reg        <= '0;
            s1_reg        <= '0;
            sigma_reg     <= '0;
            step_reg      <= '0;
            mul_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= 1'b0;
            out_score_reg <= '0;
            out_bias_reg  <= '0;
        end
        else
        begin
            if (mul_load)
            begin
                mul_reg <= mul_prod;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                OP_CLEAR:
                begin
                    clear_cnt_reg <= clear_cnt_reg + 1'b1;
                end
                OP_LOAD:
                begin
                    upd_reg   <= operation;
                    idx_reg   <= slot_ext[INDEX_BITS-1:0];
                    last_reg  <= last_feature;
                    eval_reg  <= evaluate_mode;
                    prob_reg  <= prob_clamp;
                    label_reg <= target_label;
                end
                OP_GRAD:
                begin
                    gradient_reg <= $signed({1'b0, prob_reg})
                                    - (label_reg ? 18'sd65536 : 18'sd0);
                end
                OP_SEL_BIAS:
                begin
                    slot_reg <= '0;
                    bias_reg <= 1'b1;
                end
                OP_SEL_FEAT:
                begin
                    slot_reg <= idx_reg;
                    bias_reg <= 1'b0;
                end
                OP_CAP:
                begin
                    nn_reg <= nn_sat;
                    w_reg  <= $signed(rdata_w);
                    z_reg  <= $signed(rdata_z);
                end
                OP_SQ0:
                begin
                    if (sq_done)
                    begin
                        s0_reg <= sq_root;
                    end
                end
                OP_SQ1:
                begin
                    if (sq_done)
                    begin
                        s1_reg <= sq_root;
                    end
                end
                OP_SIG:
                begin
                    if (dv_done)
                    begin
                        sigma_reg <= sigma_clip;
                    end
                end
                OP_ZUPD:
                begin
                    z_reg <= z_new;
                end
                OP_FW1:
                begin
                    if (dv_done)
                    begin
                        step_reg <= (step_sum == '0) ? STEP_W'(1) : step_sum;
                    end
                end
                OP_OPEN:
                begin
                    acc_reg  <= $signed(rdata_w);
                    open_reg <= 1'b1;
                end
                OP_ACC:
                begin
                    acc_reg <= sat32(accsum);
                end
                OP_W0:
                begin
                    w0_reg    <= $signed(rdata_w);
                    score_reg <= upd_reg ? '0 : acc_reg;
                end
                OP_EADD:
                begin
                    score_reg <= sat32(scoresum);
                end
                OP_EMIT:
                begin
                    if (emit_fire)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= upd_reg;
                        out_score_reg <= score_reg;
                        out_bias_reg  <= w0_reg;
                        open_reg      <= 1'b0;
                    end
                end
                default:
                begin
                    open_reg <= open_reg;
                end
            endcase
        end
    end

    assign status.clear_done = &clear_cnt_reg;
    assign status.sq_done    = sq_done;
    assign status.dv_done    = dv_done;
    assign status.open       = open_reg;
    assign status.is_update  = upd_reg;
    assign status.idx_zero   = (idx_reg == '0);
    assign status.last       = last_reg;
    assign status.eval       = eval_reg;
    assign status.bias       = bias_reg;
    assign status.small_z    = (absz <= l1_reg);
    assign status.out_full   = out_valid_reg;

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign raw_score   = out_score_reg;
    assign bias_weight = out_bias_reg;

    a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sq_start |-> sq_done)
        else $error("square root restarted while busy");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        dv_start |-> dv_done)
        else $error("divider restarted while busy");

    a_grad_range: assert property (@(posedge clk) disable iff (!rst_n)
        (gradient_reg >= -18'sd65536) && (gradient_reg <= 18'sd65536))
        else $error("gradient out of range");

    a_close_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(open_reg) |-> ($past(op) == OP_EMIT) && out_valid_reg)
        else $error("example closed without a result");
endmodule

// File: hdl/ftrl_ctrl.sv
`timescale 1ns / 1ps
// Sequencer that walks the datapath through clear, predict and update steps.
module ftrl_ctrl
    import ftrl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  dp_status_t status,
    output dp_op_t     op
);
    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (status.clear_done) state_next = ST_IDLE;
            ST_IDLE:     if (item_valid) state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                if (!status.open)
                    state_next = status.is_update ? ST_GRAD : ST_O_SEL;
                else if (status.idx_zero)
                    state_next = ST_FIN;
                else
                    state_next = status.is_update ? ST_LF_SEL : ST_P_SEL;
            end
            ST_GRAD:     state_next = ST_LB_SEL;
            ST_LB_SEL:   state_next = ST_L_WAIT;
            ST_LF_SEL:   state_next = ST_L_WAIT;
            ST_L_WAIT:   state_next = ST_L_CAP;
            ST_L_CAP:    state_next = ST_L_SQ0;
            ST_L_SQ0:    if (status.sq_done) state_next = ST_L_SQ1;
            ST_L_SQ1:    if (status.sq_done) state_next = ST_L_SIG;
            ST_L_SIG:    if (status.dv_done) state_next = ST_L_PMUL;
            ST_L_PMUL:   state_next = ST_L_ZUPD;
            ST_L_ZUPD:   state_next = ST_L_BR;
            ST_L_BR:
            begin
                if (status.bias)
                    state_next = ST_B_MUL;
                else
                    state_next = status.small_z ? ST_F_ZERO : ST_F_D1;
            end
            ST_B_MUL:    state_next = ST_B_DIV;
            ST_B_DIV:    state_next = ST_B_WAIT;
            ST_B_WAIT:   if (status.dv_done) state_next = ST_O_SEL;
            ST_F_ZERO:   state_next = ST_FIN;
            ST_F_D1:     state_next = ST_F_W1;
            ST_F_W1:     if (status.dv_done) state_next = ST_F_D2;
            ST_F_D2:     state_next = ST_F_W2;
            ST_F_W2:     if (status.dv_done) state_next = ST_FIN;
            ST_O_SEL:    state_next = ST_O_WAIT;
            ST_O_WAIT:   state_next = ST_O_CAP;
            ST_O_CAP:
            begin
                if (status.idx_zero)
                    state_next = ST_FIN;
                else
                    state_next = status.is_update ? ST_LF_SEL : ST_P_SEL;
            end
            ST_P_SEL:    state_next = ST_P_WAIT;
            ST_P_WAIT:   state_next = ST_P_ACC;
            ST_P_ACC:    state_next = ST_FIN;
            ST_FIN:      state_next = status.last ? ST_E_SEL : ST_IDLE;
            ST_E_SEL:    state_next = ST_E_WAIT;
            ST_E_WAIT:   state_next = ST_E_CAP;
            ST_E_CAP:
            begin
                state_next = (!status.is_update && status.eval) ? ST_E_MUL : ST_EMIT;
            end
            ST_E_MUL:    state_next = ST_E_ADD;
            ST_E_ADD:    state_next = ST_EMIT;
            ST_EMIT:     if (!status.out_full) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        op         = OP_NOP;
        item_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:  op = OP_CLEAR;
            ST_IDLE:
            begin
                item_ready = 1'b1;
                op         = item_valid ? OP_LOAD : OP_NOP;
            end
            ST_GRAD:   op = OP_GRAD;
            ST_LB_SEL: op = OP_SEL_BIAS;
            ST_LF_SEL: op = OP_SEL_FEAT;
            ST_L_CAP:  op = OP_CAP;
            ST_L_SQ0:  op = OP_SQ0;
            ST_L_SQ1:  op = OP_SQ1;
            ST_L_SIG:  op = OP_SIG;
            ST_L_PMUL: op = OP_PMUL;
            ST_L_ZUPD: op = OP_ZUPD;
            ST_B_MUL:  op = OP_BMUL;
            ST_B_DIV:  op = OP_BDIV;
            ST_B_WAIT: op = OP_WSET;
            ST_F_ZERO: op = OP_WZERO;
            ST_F_D1:   op = OP_FD1;
            ST_F_W1:   op = OP_FW1;
            ST_F_D2:   op = OP_FD2;
            ST_F_W2:   op = OP_WSET;
            ST_O_SEL:  op = OP_SEL_BIAS;
            ST_O_CAP:  op = OP_OPEN;
            ST_P_SEL:  op = OP_SEL_FEAT;
            ST_P_ACC:  op = OP_ACC;
            ST_E_SEL:  op = OP_SEL_BIAS;
            ST_E_CAP:  op = OP_W0;
            ST_E_MUL:  op = OP_EMUL;
            ST_E_ADD:  op = OP_EADD;
            ST_EMIT:   op = OP_EMIT;
            default:   op = OP_NOP;
        endcase
    end
endmodule

// File: hdl/ftrl_logistic_learner.sv
`timescale 1ns / 1ps
// Top level of the FTRL-proximal logistic learner over hashed feature tables.
// One beat at a time: a predict beat accumulates its feature weight, an update beat
// runs the FTRL update of its feature slot, and of the bias slot when it opens an example.
// A closing beat also emits the result, with dropout scaling for an evaluated prediction,
// and waits out any result stall. The square roots and divisions set the update time.
// After reset all 2**INDEX_BITS table entries are swept to zero; no beat is taken then.
module ftrl_logistic_learner
    import ftrl_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ftrl_item_if.sink     item,
    ftrl_result_if.source result,
    ftrl_cfg_if.sink      cfg
);
    dp_op_t     op;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    ftrl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .op         (op)
    );

    ftrl_datapath #(.INDEX_BITS(INDEX_BITS)) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .status        (status),
        .operation     (item.operation),
        .feature_slot  (item.feature_slot),
        .last_feature  (item.last_feature),
        .evaluate_mode (item.evaluate_mode),
        .probability   (item.probability),
        .target_label  (item.target_label),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .result_kind   (result.result_kind),
        .raw_score     (result.raw_score),
        .bias_weight   (result.bias_weight)
    );
endmodule

// File: tb/ftrl_logistic_learner_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the FTRL learner: random bursts of examples, scored against a model.
module ftrl_logistic_learner_test
    import ftrl_pkg::*;
();

    typedef struct packed {
        logic        operation;
        logic [11:0] feature_slot;
        logic        last_feature;
        logic        evaluate_mode;
        logic [16:0] probability;
        logic        target_label;
    } learn_beat_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] raw_score;
        logic signed [31:0] bias_weight;
    } learn_result_t;

    logic clk;
    logic rst_n;
    int   error_count;
    longint cycle_count;
    int   hold_off;
    bit   long_stall_done;
    int   burst_left;
    int   gap_left;
    bit   item_taken;

    ftrl_item_if   item ();
    ftrl_result_if result ();
    ftrl_cfg_if    cfg ();

    ftrl_logistic_learner dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    learn_beat_t   pending_beats[$];
    learn_result_t expected_results[$];

    logic [31:0] m_alpha = ALPHA_RST;
    logic [31:0] m_beta = BETA_RST;
    logic [31:0] m_l1 = L1_RST;
    logic [31:0] m_l2 = L2_RST;
    logic [16:0] m_drop = DROP_RST;
    logic signed [31:0] m_weight[4096] = '{default: '0};
    logic [31:0]        m_nsq[4096] = '{default: '0};
    logic signed [31:0] m_z[4096] = '{default: '0};
    logic signed [31:0] m_acc = '0;
    bit                 m_open = 1'b0;
    logic signed [31:0] m_grad = '0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] signed_mag(bit neg, logic [63:0] q);
        if (neg)
            return (q >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
        return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [11:0] pick_slot();
        int sel;
        sel = int'($urandom_range(0, 9));
        if (sel == 0)
            return 12'd0;
        if (sel < 7)
            return 12'($urandom_range(1, 15));
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [16:0] pick_prob();
        int sel;
        sel = int'($urandom_range(0, 9));
        if (sel == 0)
            return 17'd0;
        if (sel == 1)
            return 17'd65536;
        if (sel == 2)
            return 17'($urandom_range(65537, 131071));
        return 17'($urandom_range(0, 65536));
    endfunction

    task automatic ftrl_slot_update(int idx, bit is_bias);
        logic [63:0] alpha, g2, nsum, s0, s1, sigma, absz, den, step;
        longint      g, prod;
        logic [31:0] nn;
        logic signed [31:0] z;
        alpha = (m_alpha != 0) ? {32'd0, m_alpha} : 64'd1;
        g = m_grad;
        g2 = (g * g) / 65536;
        nsum = {32'd0, m_nsq[idx]} + g2;
        nn = (nsum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nsum[31:0];
        s0 = int_root({16'd0, m_nsq[idx], 16'd0});
        s1 = int_root({16'd0, nn, 16'd0});
        sigma = ((s1 - s0) << 16) / alpha;
        if (sigma > 64'h7FFF_FFFF)
            sigma = 64'h7FFF_FFFF;
        prod = ($signed(sigma) * longint'(m_weight[idx])) / 65536;
        z = clamp32(longint'(m_z[idx]) + g - prod);
        m_z[idx] = z;
        m_nsq[idx] = nn;
        absz = (z < 0) ? 64'(-longint'(z)) : 64'(longint'(z));
        if (is_bias)
        begin
            den = {32'd0, m_beta} + s1;
            if (den == 0)
                den = 1;
            m_weight[idx] = signed_mag(z > 0, (absz * alpha) / den);
        end
        else if (absz <= {32'd0, m_l1})
            m_weight[idx] = '0;
        else
        begin
            step = {32'd0, m_l2} + ((({32'd0, m_beta} + s1) << 16) / alpha);
            if (step == 0)
                step = 1;
            m_weight[idx] = signed_mag(z > 0, ((absz - {32'd0, m_l1}) << 16) / step);
        end
    endtask

    task automatic predict_beat(learn_beat_t b);
        int          idx;
        longint      prob, keep, part;
        learn_result_t r;
        idx = b.feature_slot;
        prob = b.probability;
        if (prob > 65536)
            prob = 65536;
        if (!m_open)
        begin
            if (b.operation)
            begin
                m_grad = 32'(prob - (b.target_label ? 65536 : 0));
                ftrl_slot_update(0, 1'b1);
            end
            m_acc = m_weight[0];
            m_open = 1'b1;
        end
        if (idx != 0)
        begin
            if (b.operation)
                ftrl_slot_update(idx, 1'b0);
            else
                m_acc = clamp32(longint'(m_acc) + longint'(m_weight[idx]));
        end
        if (b.last_feature)
        begin
            m_open = 1'b0;
            r.result_kind = b.operation;
            r.bias_weight = m_weight[0];
            r.raw_score = '0;
            if (!b.operation)
            begin
                r.raw_score = m_acc;
                if (b.evaluate_mode)
                begin
                    keep = 65536 - ((m_drop > 17'd65536) ? 65536 : longint'(m_drop));
                    part = ((longint'(m_acc) - longint'(m_weight[0])) * keep) / 65536;
                    r.raw_score = clamp32(part + longint'(m_weight[0]));
                end
            end
            expected_results.push_back(r);
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic model_config(logic [2:0] index, logic [31:0] data);
        case (index)
            CFG_ALPHA: m_alpha = data;
            CFG_BETA:  m_beta = data;
            CFG_L1:    m_l1 = data;
            CFG_L2:    m_l2 = data;
            CFG_DROP:  m_drop = data[16:0];
            default:   m_drop = m_drop;
        endcase
    endtask

    task automatic cfg_write(logic [2:0] index, logic [31:0] data);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        model_config(index, data);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic add_examples(int target);
        int          added;
        int          len;
        bit          upd;
        learn_beat_t b;
        added = 0;
        while (added < target)
        begin
            len = int'($urandom_range(1, 4));
            upd = 1'($urandom_range(0, 1));
            for (int k = 0; k < len; k++)
            begin
                b.operation     = ($urandom_range(0, 9) == 0) ? !upd : upd;
                b.feature_slot  = pick_slot();
                b.last_feature  = (k == len - 1);
                b.evaluate_mode = 1'($urandom_range(0, 1));
                b.probability   = pick_prob();
                b.target_label  = 1'($urandom_range(0, 1));
                pending_beats.push_back(b);
                added++;
            end
        end
    endtask

    task automatic wait_drain();
        do
            @(negedge clk);
        while ((pending_beats.size() != 0) || (expected_results.size() != 0) || item.valid);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count > 64'd3000000)
            begin
                $display("ftrl_logistic_learner_test: done, errors");
                $finish;
            end
        end
    end

    // driver: bursts and gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item.valid         <= 1'b0;
            item.operation     <= 1'b0;
            item.feature_slot  <= '0;
            item.last_feature  <= 1'b0;
            item.evaluate_mode <= 1'b0;
            item.probability   <= '0;
            item.target_label  <= 1'b0;
            burst_left         <= 0;
            gap_left           <= 0;
        end
        else if (!item.valid || item_taken)
        begin
            if (gap_left > 0)
            begin
                item.valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end
            else if (pending_beats.size() == 0)
            begin
                item.valid <= 1'b0;
            end
            else
            begin
                item.valid <= 1'b1;
                {item.operation, item.feature_slot, item.last_feature, item.evaluate_mode,
                 item.probability, item.target_label} <= pending_beats[0];
                if (burst_left > 1)
                begin
                    burst_left <= burst_left - 1;
                end
                else
                begin
                    burst_left <= int'($urandom_range(1, 6));
                    gap_left   <= int'($urandom_range(0, 12));
                end
            end
        end
    end

    // receiver: random stalls, long hold-off once
    always @(negedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (hold_off > 0)
            result.ready <= 1'b0;
        else
            result.ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_off        <= 0;
            long_stall_done <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
        end
        else if (!long_stall_done && (cycle_count == 64'd20000))
        begin
            hold_off        <= 4000;
            long_stall_done <= 1'b1;
        end
    end

    // monitor and accept tracking at the rising edge
    always @(posedge clk)
    begin
        item_taken <= rst_n && item.valid && item.ready;
        if (rst_n && item.valid && item.ready)
        begin
            predict_beat(pending_beats.pop_front());
        end
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_results.size() == 0)
                report("unexpected beat", 0, 0);
            else
            begin
                learn_result_t e;
                e = expected_results.pop_front();
                if (result.result_kind !== e.result_kind)
                    report("result_kind", 32'(result.result_kind), 32'(e.result_kind));
                if (result.raw_score !== e.raw_score)
                    report("raw_score", result.raw_score, e.raw_score);
                if (result.bias_weight !== e.bias_weight)
                    report("bias_weight", result.bias_weight, e.bias_weight);
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        cfg_write(CFG_ALPHA, 32'($urandom_range(1000, 200000)));
        cfg_write(CFG_BETA, 32'($urandom_range(0, 131072)));
        cfg_write(CFG_L1, 32'($urandom_range(0, 65536)));
        cfg_write(CFG_L2, 32'($urandom_range(0, 131072)));
        cfg_write(CFG_DROP, 32'($urandom_range(0, 65536)));
        add_examples(350);
        wait_drain();

        cfg_write(CFG_ALPHA, 32'd0);
        cfg_write(CFG_BETA, 32'd0);
        cfg_write(CFG_L1, 32'($urandom_range(0, 1000)));
        cfg_write(CFG_L2, 32'd0);
        cfg_write(CFG_DROP, 32'h0001_FFFF);
        add_examples(350);
        wait_drain();

        repeat (10) @(negedge clk);
        if ((error_count == 0) && (expected_results.size() == 0))
            $display("ftrl_logistic_learner_test: done, clean");
        else
            $display("ftrl_logistic_learner_test: done, errors");
        $finish;
    end
endmodule
